// ===== design/assert_macros.svh =====
// ---------------------------------------------------------------------------
// Assertion macros used by the I2C bit engine RTL.
// Define ASSERT_OFF to compile all checks out.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_CHK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("i2c bit engine: check failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("i2c bit engine: forbidden condition seen");
`else
`define ASSERT_CHK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== design/i2cmb_pkg.sv =====
// ---------------------------------------------------------------------------
// i2cmb_pkg
// Types, command codes and helpers of the I2C master bit engine.
// ---------------------------------------------------------------------------
package i2cmb_pkg;

    // Command codes
    localparam logic [2:0] CMD_NONE  = 3'd0;
    localparam logic [2:0] CMD_START = 3'd1;
    localparam logic [2:0] CMD_STOP  = 3'd2;
    localparam logic [2:0] CMD_WRITE = 3'd3;
    localparam logic [2:0] CMD_READ  = 3'd4;
    localparam logic [2:0] CMD_ACK   = 3'd5;
    localparam logic [2:0] CMD_NACK  = 3'd6;
    localparam logic [2:0] CMD_RACK  = 3'd7;

    // Pause register
    localparam int          CFG_W                   = 16;
    localparam logic [15:0] PAUSE_RESET             = 16'd5;
    localparam int          PAUSE_COUNTER_BITS_DEF  = 16;

    // Input request
    typedef struct packed {
        logic [2:0] func;
        logic [7:0] tx_data;
        logic       sda_in;
    } i2cmb_req_t;

    // Result
    typedef struct packed {
        logic       scl_out;
        logic       sda_out;
        logic       busy_res;
        logic       done_res;
        logic [7:0] rx_byte;
        logic       ack_received;
    } i2cmb_res_t;

    // Line phases per bit frame
    function automatic logic [2:0] phases_of(input logic [2:0] cmd);
        logic [2:0] n;
        unique case (cmd)
            CMD_STOP:          n = 3'd4;
            CMD_READ, CMD_RACK: n = 3'd3;
            default:           n = 3'd2;
        endcase
        return n;
    endfunction

    // Bit frames per command
    function automatic logic [3:0] bits_of(input logic [2:0] cmd);
        return (cmd == CMD_WRITE || cmd == CMD_READ) ? 4'd8 : 4'd1;
    endfunction

endpackage

// ===== design/i2cmb_core.sv =====
// ---------------------------------------------------------------------------
// i2cmb_core
// Command sequencer state and its per-tick update; forms one result per tick.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module i2cmb_core
    import i2cmb_pkg::*;
#(
    parameter int PAUSE_COUNTER_BITS = PAUSE_COUNTER_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             fire,
    input  i2cmb_req_t       req,
    output i2cmb_res_t       res
);

    localparam int CW = (PAUSE_COUNTER_BITS > CFG_W) ? PAUSE_COUNTER_BITS : CFG_W;

    typedef struct packed {
        logic       scl;
        logic       sda;
        logic [7:0] sh;
        logic       ack;
    } line_t;

    // Apply the line action of one phase
    function automatic line_t apply_phase(input logic [2:0] cmd, input logic [1:0] ph,
                                          input logic sda_in, input line_t cur);
        line_t r;
        r = cur;
        unique case (cmd)
            CMD_START:
            begin
                if (ph == 2'd0) r.sda = 1'b0;
                else            r.scl = 1'b0;
            end
            CMD_STOP:
            begin
                unique case (ph)
                    2'd0:    r.scl = 1'b0;
                    2'd1:    r.sda = 1'b0;
                    2'd2:    r.scl = 1'b1;
                    default: r.sda = 1'b1;
                endcase
            end
            CMD_READ, CMD_RACK:
            begin
                if (ph == 2'd0)
                begin
                    r.scl = 1'b0;
                end
                else if (ph == 2'd1)
                begin
                    r.sda = 1'b1;
                    r.scl = 1'b1;
                end
                else if (cmd == CMD_READ)
                begin
                    r.sh = {cur.sh[6:0], sda_in};
                end
                else
                begin
                    r.ack = ~sda_in;
                end
            end
            default:
            begin
                // put bit: write, ack, nack
                if (ph == 2'd0)
                begin
                    r.scl = 1'b0;
                end
                else
                begin
                    r.sda = (cmd == CMD_WRITE) ? cur.sh[7] : (cmd == CMD_NACK);
                    r.scl = 1'b1;
                end
            end
        endcase
        return r;
    endfunction

    logic [CFG_W-1:0]              pause_reg;
    logic [2:0]                    cmd_reg,  cmd_next;
    logic [1:0]                    ph_reg,   ph_next;
    logic [3:0]                    bit_reg,  bit_next;
    logic [PAUSE_COUNTER_BITS-1:0] pc_reg,   pc_next;
    line_t                         line_reg, line_next;
    logic [7:0]                    rx_reg,   rx_next;

    logic [CFG_W-1:0]              p_m1;
    logic [CW-1:0]                 p_ext;
    logic [CW-1:0]                 pc_max_ext;
    logic [PAUSE_COUNTER_BITS-1:0] reload;
    logic [2:0]                    ph_sum;
    logic [3:0]                    bit_sum;
    logic                          done;
    line_t                         line_tmp;

    // Pause reload value: zero acts as one, saturate at counter range
    always_comb
    begin
        p_m1       = (pause_reg == '0) ? '0 : pause_reg - 1'b1;
        p_ext      = CW'(p_m1);
        pc_max_ext = CW'({PAUSE_COUNTER_BITS{1'b1}});
        reload     = PAUSE_COUNTER_BITS'((p_ext > pc_max_ext) ? pc_max_ext : p_ext);
    end

    // Per-tick state update
    always_comb
    begin
        cmd_next  = cmd_reg;
        ph_next   = ph_reg;
        bit_next  = bit_reg;
        pc_next   = pc_reg;
        line_next = line_reg;
        rx_next   = rx_reg;
        done      = 1'b0;
        ph_sum    = {1'b0, ph_reg} + 3'd1;
        bit_sum   = bit_reg + 4'd1;
        line_tmp  = line_reg;

        if (cmd_reg == CMD_NONE)
        begin
            if (req.func != CMD_NONE)
            begin
                cmd_next    = req.func;
                ph_next     = 2'd0;
                bit_next    = 4'd0;
                line_tmp.sh = (req.func == CMD_WRITE) ? req.tx_data : 8'd0;
                line_next   = apply_phase(req.func, 2'd0, req.sda_in, line_tmp);
                pc_next     = reload;
            end
        end
        else if (pc_reg != '0)
        begin
            pc_next = pc_reg - 1'b1;
        end
        else
        begin
            if (ph_sum >= phases_of(cmd_reg))
            begin
                ph_next = 2'd0;
                if (cmd_reg == CMD_WRITE) line_tmp.sh = {line_reg.sh[6:0], 1'b0};
                if (bit_sum >= bits_of(cmd_reg))
                begin
                    if (cmd_reg == CMD_READ) rx_next = line_reg.sh;
                    cmd_next = CMD_NONE;
                    bit_next = 4'd0;
                    done     = 1'b1;
                end
                else
                begin
                    bit_next = bit_sum;
                end
            end
            else
            begin
                ph_next = ph_sum[1:0];
            end
            if (done)
            begin
                line_next = line_tmp;
            end
            else
            begin
                line_next = apply_phase(cmd_reg, ph_next, req.sda_in, line_tmp);
                pc_next   = reload;
            end
        end
    end

    // Result of this tick
    always_comb
    begin
        res.scl_out      = line_next.scl;
        res.sda_out      = line_next.sda;
        res.busy_res     = (cmd_next != CMD_NONE);
        res.done_res     = done;
        res.rx_byte      = rx_next;
        res.ack_received = line_next.ack;
    end

    // State registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pause_reg <= PAUSE_RESET;
            cmd_reg   <= CMD_NONE;
            ph_reg    <= 2'd0;
            bit_reg   <= 4'd0;
            pc_reg    <= '0;
            line_reg  <= '{scl: 1'b1, sda: 1'b1, sh: 8'd0, ack: 1'b0};
            rx_reg    <= 8'd0;
        end
        else
        begin
            if (cfg_we) pause_reg <= cfg_wdata;
            if (fire)
            begin
                cmd_reg  <= cmd_next;
                ph_reg   <= ph_next;
                bit_reg  <= bit_next;
                pc_reg   <= pc_next;
                line_reg <= line_next;
                rx_reg   <= rx_next;
            end
        end
    end

    // Checks
    `ASSERT_CHK(a_done_goes_idle, clk, rst_n, (fire && done) |=> (cmd_reg == CMD_NONE))
    `ASSERT_NEVER(a_idle_pause_clear, clk, rst_n, (cmd_reg == CMD_NONE) && (pc_reg != '0))
    `ASSERT_NEVER(a_bit_in_range, clk, rst_n, bit_reg >= bits_of(cmd_reg))

endmodule

// ===== design/i2cmb_out_stage.sv =====
// ---------------------------------------------------------------------------
// i2cmb_out_stage
// Result register with valid/stall handshake toward the receiver.
// ---------------------------------------------------------------------------
module i2cmb_out_stage
    import i2cmb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    output logic       fire,
    input  i2cmb_res_t res_in,
    output logic       out_valid,
    input  logic       out_stall,
    output i2cmb_res_t out_res
);

    logic       valid_reg, valid_next;
    i2cmb_res_t data_reg;

    // Take a new request when the result slot is empty or being drained
    assign in_stall = valid_reg & out_stall;
    assign fire     = in_valid & ~in_stall;

    always_comb
    begin
        if (fire)           valid_next = 1'b1;
        else if (!out_stall) valid_next = 1'b0;
        else                valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) valid_reg <= 1'b0;
        else        valid_reg <= valid_next;
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        if (fire) data_reg <= res_in;
    end

    assign out_valid = valid_reg;
    assign out_res   = data_reg;

endmodule

// ===== design/i2c_master_bit_engine_unit.sv =====
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit
// I2C master line sequencer, one request per timing tick.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall / in_req): one request is one tick.
//   While idle, a nonzero func starts start, stop, write byte, read byte,
//   ack, nack or read ack; func is ignored while a command runs.
//   Output channel (out_valid / out_stall / out_res): one result per request,
//   giving SCL, SDA drive, busy, done, last received byte and ack seen.
//   The result is registered and shows in the cycle after accept; throughput is
//   one request per cycle while the output does not stall, set by the single
//   sequencer update between the state registers and the result register.
//   A stall on the output holds the result and stalls the input channel in
//   the same cycle; no request is lost.
//   cfg_we / cfg_wdata write the ticks per line phase; write only while idle.
//   Reset: lines released high, engine idle, phase length 5 ticks, no
//   result pending.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_unit
    import i2cmb_pkg::*;
#(
    parameter int PAUSE_COUNTER_BITS = PAUSE_COUNTER_BITS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    input  logic             in_valid,
    output logic             in_stall,
    input  i2cmb_req_t       in_req,
    output logic             out_valid,
    input  logic             out_stall,
    output i2cmb_res_t       out_res
);

    logic       fire;
    i2cmb_res_t res;

    // Sequencer
    i2cmb_core #(
        .PAUSE_COUNTER_BITS (PAUSE_COUNTER_BITS)
    ) u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .fire      (fire),
        .req       (in_req),
        .res       (res)
    );

    // Result register
    i2cmb_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .fire      (fire),
        .res_in    (res),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

endmodule

// ===== sim/i2c_master_bit_engine_unit_tb.sv =====
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// i2c_master_bit_engine_unit_tb
// Self-checking bench for the I2C master bit engine. A line-level model of
// the sequencer predicts SCL, SDA, busy, done, the received byte and the ack
// for every tick request. Requests go in bursts with random gaps, and the
// result side stalls on a rotating pattern. Directed tests cover every
// command, the reset phase length and zero and short phase lengths. Random
// tests then run framed transfers (start, address, ack, data, stop) with
// noise commands mixed in.
// ---------------------------------------------------------------------------
module i2c_master_bit_engine_unit_tb;
    import i2cmb_pkg::*;

    localparam int LIMIT = 200_000;

    logic             clk       = 1'b0;
    logic             rst_n     = 1'b0;
    logic             cfg_we    = 1'b0;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             in_valid  = 1'b0;
    logic             in_stall;
    i2cmb_req_t       in_req    = '0;
    logic             out_valid;
    logic             out_stall = 1'b0;
    i2cmb_res_t       out_res;

    // Bench control
    int          errors     = 0;
    int          cycle_count = 0;
    int          burst_left = 0;
    int          cmd_issued = 0;
    logic        quiet      = 1'b0;
    logic [15:0] stall_pat  = 16'h0000;
    logic [3:0]  stall_pos  = 4'd0;

    // Sequencer model state
    logic [15:0] pause_cfg = PAUSE_RESET;
    logic [2:0]  eng_cmd   = CMD_NONE;
    logic [2:0]  eng_phase = 3'd0;
    logic [3:0]  eng_bits  = 4'd0;
    logic [15:0] eng_pause = 16'd0;
    logic [7:0]  eng_shift = 8'd0;
    logic        eng_scl   = 1'b1;
    logic        eng_sda   = 1'b1;
    logic [7:0]  eng_rx    = 8'd0;
    logic        eng_ack   = 1'b0;

    i2cmb_res_t  line_state_q[$];

    i2c_master_bit_engine_unit dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_req    (in_req),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_res   (out_res)
    );

    always #5 clk = ~clk;

    // -----------------------------------------------------------------------
    // Line model
    // -----------------------------------------------------------------------

    // Hold count reloaded at each phase; a zero setting behaves as one tick
    function automatic logic [15:0] phase_hold();
        return (pause_cfg == 16'd0) ? 16'd0 : pause_cfg - 16'd1;
    endfunction

    // Pin action on the first tick of a phase
    function automatic void line_phase(input logic [2:0] cmd, input logic [2:0] ph,
                                       input logic sda);
        case (cmd)
            CMD_START:
                if (ph == 3'd0) eng_sda = 1'b0;
                else eng_scl = 1'b0;
            CMD_STOP:
                case (ph)
                    3'd0:    eng_scl = 1'b0;
                    3'd1:    eng_sda = 1'b0;
                    3'd2:    eng_scl = 1'b1;
                    default: eng_sda = 1'b1;
                endcase
            CMD_READ, CMD_RACK:
                if (ph == 3'd0)
                begin
                    eng_scl = 1'b0;
                end
                else if (ph == 3'd1)
                begin
                    eng_sda = 1'b1;
                    eng_scl = 1'b1;
                end
                else if (cmd == CMD_READ)
                begin
                    eng_shift = {eng_shift[6:0], sda};
                end
                else
                begin
                    eng_ack = ~sda;
                end
            default:
                if (ph == 3'd0)
                begin
                    eng_scl = 1'b0;
                end
                else
                begin
                    eng_sda = (cmd == CMD_WRITE) ? eng_shift[7] : (cmd == CMD_NACK);
                    eng_scl = 1'b1;
                end
        endcase
    endfunction

    // One tick of the sequencer; returns the line state after the update
    function automatic i2cmb_res_t bus_tick(input i2cmb_req_t r);
        i2cmb_res_t res;
        logic       fin;
        logic [2:0] nphase;
        logic [3:0] nbits;
        fin = 1'b0;
        if (eng_cmd == CMD_NONE)
        begin
            if (r.func != CMD_NONE)
            begin
                eng_cmd   = r.func;
                eng_phase = 3'd0;
                eng_bits  = 4'd0;
                eng_shift = (r.func == CMD_WRITE) ? r.tx_data : 8'd0;
                line_phase(r.func, 3'd0, r.sda_in);
                eng_pause = phase_hold();
            end
        end
        else if (eng_pause != 16'd0)
        begin
            eng_pause = eng_pause - 16'd1;
        end
        else
        begin
            case (eng_cmd)
                CMD_STOP:           nphase = 3'd4;
                CMD_READ, CMD_RACK: nphase = 3'd3;
                default:            nphase = 3'd2;
            endcase
            nbits = (eng_cmd == CMD_WRITE || eng_cmd == CMD_READ) ? 4'd8 : 4'd1;
            eng_phase = eng_phase + 3'd1;
            if (eng_phase >= nphase)
            begin
                eng_phase = 3'd0;
                eng_bits  = eng_bits + 4'd1;
                if (eng_cmd == CMD_WRITE) eng_shift = eng_shift << 1;
                if (eng_bits >= nbits)
                begin
                    if (eng_cmd == CMD_READ) eng_rx = eng_shift;
                    eng_cmd  = CMD_NONE;
                    eng_bits = 4'd0;
                    fin      = 1'b1;
                end
            end
            if (!fin)
            begin
                line_phase(eng_cmd, eng_phase, r.sda_in);
                eng_pause = phase_hold();
            end
        end
        res.scl_out      = eng_scl;
        res.sda_out      = eng_sda;
        res.busy_res     = (eng_cmd != CMD_NONE);
        res.done_res     = fin;
        res.rx_byte      = eng_rx;
        res.ack_received = eng_ack;
        return res;
    endfunction

    // -----------------------------------------------------------------------
    // Result checking
    // -----------------------------------------------------------------------

    task automatic check_field(input string name, input logic [7:0] exp_v,
                               input logic [7:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %0h actual %0h", $time, name, exp_v, act_v);
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        i2cmb_res_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (line_state_q.size() == 0)
            begin
                $display("%0t: unexpected result, expected none actual %0h", $time, out_res);
                errors++;
            end
            else
            begin
                exp_res = line_state_q.pop_front();
                check_field("scl_out", exp_res.scl_out, out_res.scl_out);
                check_field("sda_out", exp_res.sda_out, out_res.sda_out);
                check_field("busy_res", exp_res.busy_res, out_res.busy_res);
                check_field("done_res", exp_res.done_res, out_res.done_res);
                check_field("rx_byte", exp_res.rx_byte, out_res.rx_byte);
                check_field("ack_received", exp_res.ack_received, out_res.ack_received);
            end
        end
    end

    // Result-side stall on a rotating pattern, reshuffled each time the pattern position wraps
    always @(negedge clk)
    begin
        if (stall_pos == 4'd0)
        begin
            case ($urandom_range(0, 7))
                0, 1:    stall_pat = 16'h0000;
                2, 3:    stall_pat = 16'($urandom & $urandom);
                4:       stall_pat = 16'hFFFF;
                default: stall_pat = 16'($urandom);
            endcase
        end
        out_stall <= quiet ? 1'b0 : stall_pat[stall_pos];
        stall_pos = stall_pos + 4'd1;
    end

    // Watchdog
    initial
    begin
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Test completed with failures");
        $finish;
    end

    // -----------------------------------------------------------------------
    // Stimulus helpers
    // -----------------------------------------------------------------------

    // Send one tick request in bursts with gaps; predict on acceptance
    task automatic send_tick(input i2cmb_req_t r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 24);
            gap = quiet ? 0 : $urandom_range(0, 4);
            if (gap > 0)
            begin
                @(negedge clk);
                in_valid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        @(negedge clk);
        in_valid <= 1'b1;
        in_req   <= r;
        do @(posedge clk); while (in_stall);
        line_state_q.push_back(bus_tick(r));
        burst_left--;
    endtask

    // Drop valid and wait for all outstanding results
    task automatic settle();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (line_state_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // Phase length write, only with the engine idle and nothing in flight
    task automatic write_pause(input logic [15:0] v);
        settle();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(negedge clk);
        cfg_we    <= 1'b0;
        pause_cfg = v;
    endtask

    task automatic idle_ticks(input int n);
        i2cmb_req_t r;
        repeat (n)
        begin
            r.func    = CMD_NONE;
            r.tx_data = 8'($urandom);
            r.sda_in  = 1'($urandom);
            send_tick(r);
        end
    endtask

    // Issue a command and tick until it completes. The slave answers read
    // bits MSB first from slave_byte; noise 1 mixes in stray commands and
    // SDA glitches, noise 2 puts a command on every busy tick.
    task automatic run_command(input logic [2:0] cmd, input logic [7:0] tx,
                               input logic [7:0] slave_byte, input int noise);
        i2cmb_req_t r;
        r.func    = cmd;
        r.tx_data = tx;
        r.sda_in  = slave_byte[7];
        if (cmd != CMD_NONE) cmd_issued++;
        send_tick(r);
        while (eng_cmd != CMD_NONE)
        begin
            r.tx_data = 8'($urandom);
            r.sda_in  = slave_byte[3'd7 - eng_bits[2:0]];
            if (noise == 2)
                r.func = 3'($urandom_range(1, 7));
            else if (noise == 1 && $urandom_range(0, 3) == 0)
                r.func = 3'($urandom);
            else
                r.func = CMD_NONE;
            if (noise == 1 && $urandom_range(0, 15) == 0) r.sda_in = 1'($urandom);
            send_tick(r);
        end
    endtask

    // -----------------------------------------------------------------------
    // Tests
    // -----------------------------------------------------------------------

    // Start and stop at the reset phase length
    task automatic test_reset_pause();
        idle_ticks(3);
        run_command(CMD_START, 8'h00, 8'hFF, 0);
        run_command(CMD_STOP, 8'h00, 8'hFF, 0);
        idle_ticks(2);
    endtask

    // Every command at a one-tick phase length
    task automatic test_each_command();
        write_pause(16'd1);
        run_command(CMD_START, 8'h00, 8'hFF, 0);
        run_command(CMD_WRITE, 8'h00, 8'hFF, 0);
        run_command(CMD_WRITE, 8'hFF, 8'h00, 0);
        run_command(CMD_RACK, 8'h00, 8'h00, 0);
        run_command(CMD_RACK, 8'hFF, 8'hFF, 0);
        run_command(CMD_READ, 8'h00, 8'hA5, 0);
        run_command(CMD_ACK, 8'h00, 8'hFF, 0);
        run_command(CMD_READ, 8'h00, 8'h5A, 0);
        run_command(CMD_NACK, 8'h00, 8'hFF, 0);
        run_command(CMD_STOP, 8'h00, 8'hFF, 0);
        idle_ticks(2);
    endtask

    // Commands arriving while busy, including on the completing tick
    task automatic test_busy_commands();
        run_command(CMD_WRITE, 8'h3C, 8'hFF, 2);
        run_command(CMD_READ, 8'h00, 8'hC3, 2);
        run_command(CMD_STOP, 8'h00, 8'hFF, 2);
    endtask

    // Zero and two-tick phase lengths
    task automatic test_pause_extremes();
        write_pause(16'd0);
        run_command(CMD_START, 8'h00, 8'hFF, 0);
        run_command(CMD_STOP, 8'h00, 8'hFF, 0);
        write_pause(16'd2);
        run_command(CMD_START, 8'h00, 8'hFF, 0);
        run_command(CMD_WRITE, 8'h81, 8'hFF, 0);
        run_command(CMD_RACK, 8'h00, 8'h7F, 0);
        run_command(CMD_STOP, 8'h00, 8'hFF, 0);
    endtask

    // Framed transfers with random content, plus stray commands and noise
    task automatic test_random_traffic();
        int          stop_at;
        int          n;
        logic [15:0] p;
        for (int ph = 0; ph < 2; ph++)
        begin
            p = ($urandom_range(0, 1) == 1) ? 16'd1 : 16'd0;
            write_pause(p);
            quiet   = (ph == 1);
            stop_at = cmd_issued + 5;
            while (cmd_issued < stop_at)
            begin
                if ($urandom_range(0, 3) != 0)
                begin
                    run_command(CMD_START, 8'($urandom), 8'($urandom), 1);
                    run_command(CMD_WRITE, 8'($urandom), 8'($urandom), 1);
                    run_command(CMD_RACK, 8'($urandom), 8'($urandom), 1);
                    n = $urandom_range(0, 3);
                    repeat (n)
                    begin
                        if ($urandom_range(0, 1) == 1)
                        begin
                            run_command(CMD_READ, 8'($urandom), 8'($urandom), 1);
                            run_command($urandom_range(0, 1) ? CMD_ACK : CMD_NACK,
                                        8'($urandom), 8'($urandom), 1);
                        end
                        else
                        begin
                            run_command(CMD_WRITE, 8'($urandom), 8'($urandom), 1);
                            run_command(CMD_RACK, 8'($urandom), 8'($urandom), 1);
                        end
                    end
                    run_command(CMD_STOP, 8'($urandom), 8'($urandom), 1);
                end
                else
                begin
                    run_command(3'($urandom), 8'($urandom), 8'($urandom), 1);
                end
                if ($urandom_range(0, 2) == 0) idle_ticks($urandom_range(1, 5));
            end
        end
        quiet = 1'b0;
    endtask

    // -----------------------------------------------------------------------
    // Main sequence
    // -----------------------------------------------------------------------
    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_reset_pause();
        test_each_command();
        test_busy_commands();
        test_pause_extremes();
        test_random_traffic();
        write_pause(PAUSE_RESET);
        run_command(CMD_START, 8'h00, 8'hFF, 0);
        run_command(CMD_STOP, 8'h00, 8'hFF, 0);

        settle();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+design
design/i2cmb_pkg.sv
design/i2cmb_core.sv
design/i2cmb_out_stage.sv
design/i2c_master_bit_engine_unit.sv
sim/i2c_master_bit_engine_unit_tb.sv
